// ===== hdl/dsw_pkg.sv =====
`default_nettype none

package dsw_pkg;

    localparam int GROUPS      = 16;
    localparam int ORDINATES   = 16;
    localparam int G_W         = 4;
    localparam int O_W         = 4;
    localparam int TAB_DEPTH   = GROUPS * ORDINATES;
    localparam int TAB_AW      = $clog2(TAB_DEPTH);
    localparam int REFL_W      = 17;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 232;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_REFL_LEFT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFL_RIGHT = 1'b1;

    typedef enum logic [3:0] {
        OP_BND,
        OP_READ,
        OP_STLEN,
        OP_MUINC,
        OP_SL,
        OP_SR,
        OP_AA,
        OP_MM,
        OP_AS1,
        OP_MS2,
        OP_MS1,
        OP_AS2,
        OP_DIVL,
        OP_DIVR,
        OP_WB
    } t_op;

    typedef struct packed {
        logic load;
        logic go;
        logic active;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic in_ok;
        logic is_cell;
        logic det_zero;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/dfem_slab_transport_sweep_cell.sv =====
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata 232 bits, tuser 1 bit
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata 64 bits, tuser 2 bits
// cfg       in         i_cfg_we                        i_cfg_idx, i_cfg_data
//
// A cell item makes ten passes through the shared 32x32 multiplier (five narrow, five
// four-part), two divider runs (cut short when the quotient overflows), a table read and a
// write-back. A zero determinant skips the numerators and divisions; a boundary item
// makes a single multiplier pass. One item is worked at a time; a result not yet taken
// holds the next cell item at its write-back. Reset is synchronous and active low.
`default_nettype none

module dfem_slab_transport_sweep_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // group_index, ordinate_index, mu, total_xs, cell_length, src_left,
    // src_right, bound_src, reflected_flux, zero padding
    input  wire logic [dsw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // action
    input  wire logic [0:0]                          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // flux_left, flux_right
    output logic [dsw_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // saturated, singular
    output logic [1:0]                               m_axis_tuser,
    input  wire logic                                i_cfg_we,
    input  wire logic [dsw_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [dsw_pkg::REFL_W-1:0]          i_cfg_data
);
    import dsw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dsw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    dsw_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser[0]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tuser    (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/dsw_mul.sv =====
`default_nettype none

module dsw_mul (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [63:0]         i_a,
    input  wire logic [63:0]         i_b,
    input  wire logic                i_neg,
    input  wire logic                i_wide,
    output logic                     o_done,
    output logic signed [127:0]      o_prod
);
    import dsw_pkg::*;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_neg;
    logic         r_wide;
    logic         r_busy;
    logic [2:0]   r_cnt;
    logic [63:0]  r_pp;
    logic [1:0]   r_psh;
    logic         r_pv;
    logic [127:0] r_acc;
    logic         r_done;
    logic [127:0] r_prod;

    logic [2:0]   n_parts;
    logic [31:0]  n_opa;
    logic [31:0]  n_opb;
    logic [1:0]   n_sh;

    assign n_parts = r_wide ? 3'd4 : 3'd1;

    always_comb begin
        case (r_cnt)
            3'd0: begin
                n_opa = r_a[31:0];  n_opb = r_b[31:0];  n_sh = 2'd0;
            end
            3'd1: begin
                n_opa = r_a[31:0];  n_opb = r_b[63:32]; n_sh = 2'd1;
            end
            3'd2: begin
                n_opa = r_a[63:32]; n_opb = r_b[31:0];  n_sh = 2'd1;
            end
            default: begin
                n_opa = r_a[63:32]; n_opb = r_b[63:32]; n_sh = 2'd2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pv   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_neg  <= i_neg;
                r_wide <= i_wide;
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_pv   <= 1'b0;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_pv) begin
                    r_acc <= r_acc + (128'(r_pp) << (7'(r_psh) * 7'd32));
                end
                if (r_cnt < n_parts) begin
                    r_pp  <= 64'(n_opa) * 64'(n_opb);
                    r_psh <= n_sh;
                    r_pv  <= 1'b1;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_cnt == n_parts && !r_pv) begin
                    r_prod <= r_neg ? 128'(-r_acc) : r_acc;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(r_prod);

endmodule

`default_nettype wire

// ===== hdl/dsw_div.sv =====
`default_nettype none

module dsw_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [127:0]  i_num,
    input  wire logic [97:0]   i_den,
    output logic               o_done,
    output logic [31:0]        o_quot,
    output logic               o_ovf
);
    import dsw_pkg::*;

    logic [97:0]  r_den;
    logic [97:0]  r_rem;
    logic [31:0]  r_low;
    logic [31:0]  r_quot;
    logic [5:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic         r_ovf;

    logic [98:0]  n_rem2;
    logic [99:0]  n_diff;

    assign n_rem2 = {r_rem, r_low[31]};
    assign n_diff = {1'b0, n_rem2} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den  <= i_den;
                r_low  <= i_num[31:0];
                r_quot <= '0;
                r_cnt  <= 6'd32;
                if ({2'b0, i_num[127:32]} >= i_den) begin
                    // Quotient would need more than 32 bits.
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_ovf  <= 1'b0;
                    r_rem  <= {2'b0, i_num[127:32]};
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_low <= {r_low[30:0], 1'b0};
                if (n_diff[99]) begin
                    r_rem  <= n_rem2[97:0];
                    r_quot <= {r_quot[30:0], 1'b0};
                end else begin
                    r_rem  <= n_diff[97:0];
                    r_quot <= {r_quot[30:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_ovf  = r_ovf;

endmodule

`default_nettype wire

// ===== hdl/dsw_datapath.sv =====
`default_nettype none

module dsw_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dsw_pkg::t_cmd                   i_cmd,
    output dsw_pkg::t_stat                       o_stat,
    input  wire logic [dsw_pkg::IN_TDATA_W-1:0]  i_tdata,
    input  wire logic                            i_tuser,
    input  wire logic                            i_cfg_we,
    input  wire logic [dsw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [dsw_pkg::REFL_W-1:0]      i_cfg_data,
    output logic                                 o_tvalid,
    input  wire logic                            i_tready,
    output logic [dsw_pkg::OUT_TDATA_W-1:0]      o_tdata,
    output logic [1:0]                           o_tuser
);
    import dsw_pkg::*;

    logic [31:0]         mem [TAB_DEPTH];

    logic [REFL_W-1:0]   r_refl_left;
    logic [REFL_W-1:0]   r_refl_right;

    logic [TAB_AW-1:0]   r_addr;
    logic                r_right;
    logic signed [31:0]  r_mu;
    logic [30:0]         r_st;
    logic [30:0]         r_len;
    logic signed [31:0]  r_sl;
    logic signed [31:0]  r_sr;
    logic signed [31:0]  r_bs;
    logic signed [31:0]  r_rf;
    logic signed [31:0]  r_inc;
    logic                r_rd_done;

    logic signed [48:0]  r_a;
    logic signed [48:0]  r_tm;
    logic signed [49:0]  r_s1;
    logic signed [49:0]  r_s2;
    logic [97:0]         r_det;
    logic signed [127:0] r_nl;
    logic signed [127:0] r_nr;
    logic signed [31:0]  r_fl;
    logic signed [31:0]  r_fr;
    logic                r_sat;
    logic                r_sing;

    logic                r_oval;
    logic [OUT_TDATA_W-1:0] r_otdata;
    logic [1:0]          r_otuser;

    logic [G_W-1:0]      n_g;
    logic [O_W-1:0]      n_o;
    logic                n_mul_start;
    logic [63:0]         n_ma;
    logic [63:0]         n_mb;
    logic                n_mneg;
    logic                n_mwide;
    logic                mul_done;
    logic signed [127:0] mul_prod;
    logic                n_div_start;
    logic [127:0]        n_nmag;
    logic                div_done;
    logic [31:0]         div_quot;
    logic                div_ovf;
    logic                n_qneg;
    logic                n_big;
    logic signed [31:0]  n_qval;
    logic                n_wb_ok;
    logic                n_done;
    logic signed [34:0]  n_bval;
    logic signed [31:0]  n_bclamp;
    logic signed [48:0]  n_mu49;
    logic signed [49:0]  n_tm50;
    logic signed [49:0]  n_s2p;

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x[63] ? 64'(-x) : 64'(x);
    endfunction

    assign n_g = i_tdata[3:0];
    assign n_o = i_tdata[7:4];

    assign o_stat.in_ok    = (32'(n_g) < 32'(GROUPS)) && (32'(n_o) < 32'(ORDINATES));
    assign o_stat.is_cell  = i_tuser;
    assign o_stat.det_zero = (r_a == '0) && (r_mu == '0);
    assign o_stat.done     = n_done;

    assign n_mu49 = {{17{r_mu[31]}}, r_mu};
    assign n_tm50 = {r_tm[48], r_tm};
    assign n_s2p  = mul_prod[65:16];

    always_comb begin
        n_mul_start = i_cmd.go;
        n_mwide     = 1'b0;
        n_ma        = '0;
        n_mb        = '0;
        n_mneg      = 1'b0;
        unique case (i_cmd.op)
            OP_BND: begin
                n_ma   = (r_right ? 64'(r_refl_left) : 64'(r_refl_right));
                n_mb   = abs64(64'(r_rf));
                n_mneg = r_rf[31];
            end
            OP_STLEN: begin
                n_ma = 64'(r_st);
                n_mb = 64'(r_len);
            end
            OP_MUINC: begin
                n_ma   = abs64(64'(r_mu));
                n_mb   = abs64(64'(r_inc));
                n_mneg = r_mu[31] ^ r_inc[31];
            end
            OP_SL: begin
                n_ma   = 64'(r_len);
                n_mb   = abs64(64'(r_sl));
                n_mneg = r_sl[31];
            end
            OP_SR: begin
                n_ma   = 64'(r_len);
                n_mb   = abs64(64'(r_sr));
                n_mneg = r_sr[31];
            end
            OP_AA: begin
                n_ma    = abs64(64'(r_a));
                n_mb    = abs64(64'(r_a));
                n_mwide = 1'b1;
            end
            OP_MM: begin
                n_ma = abs64(64'(r_mu));
                n_mb = abs64(64'(r_mu));
            end
            OP_AS1: begin
                n_ma    = abs64(64'(r_a));
                n_mb    = abs64(64'(r_s1));
                n_mneg  = r_a[48] ^ r_s1[49];
                n_mwide = 1'b1;
            end
            OP_MS2: begin
                n_ma    = abs64(64'(r_mu));
                n_mb    = abs64(64'(r_s2));
                n_mneg  = r_mu[31] ^ r_s2[49];
                n_mwide = 1'b1;
            end
            OP_MS1: begin
                n_ma    = abs64(64'(r_mu));
                n_mb    = abs64(64'(r_s1));
                n_mneg  = r_mu[31] ^ r_s1[49];
                n_mwide = 1'b1;
            end
            OP_AS2: begin
                n_ma    = abs64(64'(r_a));
                n_mb    = abs64(64'(r_s2));
                n_mneg  = r_a[48] ^ r_s2[49];
                n_mwide = 1'b1;
            end
            default: begin
                n_mul_start = 1'b0;
            end
        endcase
    end

    assign n_div_start = i_cmd.go && (i_cmd.op == OP_DIVL || i_cmd.op == OP_DIVR);
    assign n_qneg      = (i_cmd.op == OP_DIVL) ? r_nl[127] : r_nr[127];
    assign n_nmag      = (i_cmd.op == OP_DIVL) ? (r_nl[127] ? 128'(-r_nl) : 128'(r_nl))
                                               : (r_nr[127] ? 128'(-r_nr) : 128'(r_nr));

    always_comb begin
        if (n_qneg) begin
            n_big  = div_ovf || (div_quot > 32'h8000_0000);
            n_qval = n_big ? 32'sh8000_0000 : $signed(32'(-div_quot));
        end else begin
            n_big  = div_ovf || div_quot[31];
            n_qval = n_big ? 32'sh7FFF_FFFF : $signed(div_quot);
        end
    end

    assign n_bval   = {{3{r_bs[31]}}, r_bs} + {mul_prod[49], mul_prod[49:16]};
    assign n_bclamp = (n_bval[34:31] == 4'b0000 || n_bval[34:31] == 4'b1111)
                    ? n_bval[31:0]
                    : (n_bval[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    assign n_wb_ok = !r_oval || i_tready;

    always_comb begin
        case (i_cmd.op) inside
            OP_READ:          n_done = r_rd_done;
            OP_DIVL, OP_DIVR: n_done = div_done;
            OP_WB:            n_done = n_wb_ok;
            default:          n_done = mul_done;
        endcase
        n_done = n_done && i_cmd.active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refl_left  <= '0;
            r_refl_right <= '0;
            r_rd_done    <= 1'b0;
            r_oval       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_REFL_LEFT:  r_refl_left  <= i_cfg_data;
                    CFG_REFL_RIGHT: r_refl_right <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rd_done <= i_cmd.go && (i_cmd.op == OP_READ);
            if (n_done && i_cmd.op == OP_WB) begin
                r_oval <= 1'b1;
            end else if (i_tready) begin
                r_oval <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr  <= TAB_AW'(32'(n_g) + 32'(GROUPS) * 32'(n_o));
            r_right <= 32'(n_o) >= 32'(ORDINATES / 2);
            r_mu    <= i_tdata[39:8];
            r_st    <= i_tdata[70:40];
            r_len   <= i_tdata[101:71];
            r_sl    <= i_tdata[133:102];
            r_sr    <= i_tdata[165:134];
            r_bs    <= i_tdata[197:166];
            r_rf    <= i_tdata[229:198];
        end
        if (i_cmd.go && i_cmd.op == OP_READ) begin
            r_inc  <= mem[r_addr];
            r_sat  <= 1'b0;
            r_sing <= 1'b0;
        end
        if (n_done) begin
            case (i_cmd.op)
                OP_BND:   mem[r_addr] <= n_bclamp;
                OP_STLEN: r_a  <= (r_right ? n_mu49 : -n_mu49)
                                 + $signed({1'b0, mul_prod[63:16]});
                OP_MUINC: r_tm <= mul_prod[63:15];
                OP_SL:    r_s1 <= mul_prod[65:16];
                OP_SR: begin
                    if (r_right) begin
                        r_s1 <= r_s1 + n_tm50;
                        r_s2 <= n_s2p;
                    end else begin
                        r_s2 <= n_s2p - n_tm50;
                    end
                end
                OP_AA:    r_det <= mul_prod[97:0];
                OP_MM: begin
                    r_det  <= r_det + mul_prod[97:0];
                    r_sing <= o_stat.det_zero;
                    if (o_stat.det_zero) begin
                        r_fl <= '0;
                        r_fr <= '0;
                    end
                end
                OP_AS1:   r_nl <= mul_prod;
                OP_MS2:   r_nl <= r_nl - mul_prod;
                OP_MS1:   r_nr <= mul_prod;
                OP_AS2:   r_nr <= r_nr + mul_prod;
                OP_DIVL: begin
                    r_fl  <= n_qval;
                    r_sat <= r_sat | n_big;
                end
                OP_DIVR: begin
                    r_fr  <= n_qval;
                    r_sat <= r_sat | n_big;
                end
                OP_WB: begin
                    mem[r_addr] <= r_right ? r_fr : r_fl;
                    r_otdata    <= {r_fr, r_fl};
                    r_otuser    <= {r_sing, r_sat};
                end
                default: ;
            endcase
        end
    end

    dsw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_mul_start),
        .i_a     (n_ma),
        .i_b     (n_mb),
        .i_neg   (n_mneg),
        .i_wide  (n_mwide),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    dsw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   ({n_nmag[111:0], 16'b0}),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_ovf   (div_ovf)
    );

    assign o_tvalid = r_oval;
    assign o_tdata  = r_otdata;
    assign o_tuser  = r_otuser;

endmodule

`default_nettype wire

// ===== hdl/dsw_ctrl.sv =====
`default_nettype none

module dsw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tvalid,
    output logic                 o_tready,
    input  wire dsw_pkg::t_stat  i_stat,
    output dsw_pkg::t_cmd        o_cmd
);
    import dsw_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic   n_accept;

    function automatic t_op next_op(input t_op op, input logic det_zero);
        t_op r;
        unique case (op)
            OP_READ:  r = OP_STLEN;
            OP_STLEN: r = OP_MUINC;
            OP_MUINC: r = OP_SL;
            OP_SL:    r = OP_SR;
            OP_SR:    r = OP_AA;
            OP_AA:    r = OP_MM;
            OP_MM:    r = det_zero ? OP_WB : OP_AS1;
            OP_AS1:   r = OP_MS2;
            OP_MS2:   r = OP_MS1;
            OP_MS1:   r = OP_AS2;
            OP_AS2:   r = OP_DIVL;
            OP_DIVL:  r = OP_DIVR;
            default:  r = OP_WB;
        endcase
        return r;
    endfunction

    assign o_tready     = (r_state == ST_IDLE);
    assign n_accept     = i_tvalid && o_tready;
    assign o_cmd.load   = n_accept;
    assign o_cmd.go     = (r_state == ST_ISSUE);
    assign o_cmd.active = (r_state == ST_WAIT);
    assign o_cmd.op     = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_BND;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept && i_stat.in_ok) begin
                        r_op    <= i_stat.is_cell ? OP_READ : OP_BND;
                        r_state <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (i_stat.done) begin
                        if (r_op == OP_BND || r_op == OP_WB) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_op    <= next_op(r_op, i_stat.det_zero);
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dsw_checker.sv =====
`default_nettype none

module dsw_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [63:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0 && !m_axis_tuser[0])
        else $error("singular result with nonzero flux or saturation");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again straight after an item");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind dfem_slab_transport_sweep_cell dsw_checker u_dsw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
